>>> src/lcs_pkg.sv
package lcs_pkg;

  // Field widths of the transfer payloads.
  localparam int CoefWidth   = 16;
  localparam int OutWidth    = 48;
  localparam int FracBitsDef = 16;

  typedef struct packed {
    logic signed [CoefWidth-1:0] coef_a1;
    logic signed [CoefWidth-1:0] coef_b1;
    logic signed [CoefWidth-1:0] const_c1;
    logic signed [CoefWidth-1:0] coef_a2;
    logic signed [CoefWidth-1:0] coef_b2;
    logic signed [CoefWidth-1:0] const_c2;
  } lcs_in_t;

  typedef struct packed {
    logic                       status;
    logic signed [OutWidth-1:0] sol_x;
    logic signed [OutWidth-1:0] sol_y;
  } lcs_out_t;

endpackage

>>> src/linear_2x2_cramer_solver.sv
// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+---------------------------------
// in      | input     | in_valid_i / in_stall_o | in_data_i  (coefficients, consts)
// out     | output    | out_valid_o/out_stall_i | out_data_o (status, sol_x, sol_y)
//
// One transfer can be taken on every cycle while the output is not stalled. Each result
// passes the product, difference and sign stages, then the restoring divider, which
// resolves one quotient bit per pipeline stage, and last the output register.
// Reset clears the valid bits of every stage and of the output register only.
// The whole pipeline advances together; it holds while a result waits at a stalled
// output, and in_stall_o is raised for exactly those cycles, so nothing is lost.
module linear_2x2_cramer_solver #(
  parameter int FRAC_BITS = lcs_pkg::FracBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lcs_pkg::lcs_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lcs_pkg::lcs_out_t out_data_o
);

  localparam int CW = lcs_pkg::CoefWidth;
  localparam int OW = lcs_pkg::OutWidth;
  // Product width, and width of a difference of two products.
  localparam int PW = 2 * CW;
  localparam int DW = PW + 1;
  // The magnitude of a difference always fits in DW unsigned bits.
  localparam int MW = DW;
  // Number of quotient bits, one divider stage each.
  localparam int QW = MW + FRAC_BITS;
  // Width used for the saturation compare.
  localparam int EW = ((QW > OW) ? QW : OW) + 1;

  // The pipeline moves as a unit whenever the output register can take a new value.
  logic en;
  logic out_valid_q;
  lcs_pkg::lcs_out_t out_data_q;

  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Stage one: the six full-width products.
  logic v1_q;
  logic signed [PW-1:0] p_a1b2_q, p_a2b1_q, p_c1b2_q, p_c2b1_q, p_a1c2_q, p_a2c1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_a1b2_q <= $signed(in_data_i.coef_a1) * $signed(in_data_i.coef_b2);
      p_a2b1_q <= $signed(in_data_i.coef_a2) * $signed(in_data_i.coef_b1);
      p_c1b2_q <= $signed(in_data_i.const_c1) * $signed(in_data_i.coef_b2);
      p_c2b1_q <= $signed(in_data_i.const_c2) * $signed(in_data_i.coef_b1);
      p_a1c2_q <= $signed(in_data_i.coef_a1) * $signed(in_data_i.const_c2);
      p_a2c1_q <= $signed(in_data_i.coef_a2) * $signed(in_data_i.const_c1);
    end
  end

  // Stage two: determinant and the two numerators, exact in DW bits.
  logic v2_q;
  logic signed [DW-1:0] det_q, nx_q, ny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= DW'(p_a1b2_q) - DW'(p_a2b1_q);
      nx_q  <= DW'(p_c1b2_q) - DW'(p_c2b1_q);
      ny_q  <= DW'(p_a1c2_q) - DW'(p_a2c1_q);
    end
  end

  // Stage three: magnitudes, quotient signs and the singular flag. This stage
  // feeds element zero of the divider arrays.
  logic [MW-1:0] dmag;
  logic [MW-1:0] nxmag;
  logic [MW-1:0] nymag;

  assign dmag  = det_q[DW-1] ? MW'(-det_q) : MW'(det_q);
  assign nxmag = nx_q[DW-1]  ? MW'(-nx_q)  : MW'(nx_q);
  assign nymag = ny_q[DW-1]  ? MW'(-ny_q)  : MW'(ny_q);

  logic          dv_v_q   [0:QW];
  logic          dv_sng_q [0:QW];
  logic          dv_ngx_q [0:QW];
  logic          dv_ngy_q [0:QW];
  logic [MW-1:0] dv_den_q [0:QW];
  logic [MW-1:0] dv_rx_q  [0:QW];
  logic [MW-1:0] dv_ry_q  [0:QW];
  logic [QW-1:0] dv_nx_q  [0:QW];
  logic [QW-1:0] dv_ny_q  [0:QW];
  logic [QW-1:0] dv_qx_q  [0:QW];
  logic [QW-1:0] dv_qy_q  [0:QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= v2_q;
    end
  end

  // The dividend is the numerator magnitude scaled by 2^FRAC_BITS, fed in from the top.
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_sng_q[0] <= (det_q == '0);
      dv_ngx_q[0] <= nx_q[DW-1] ^ det_q[DW-1];
      dv_ngy_q[0] <= ny_q[DW-1] ^ det_q[DW-1];
      dv_den_q[0] <= dmag;
      dv_rx_q[0]  <= '0;
      dv_ry_q[0]  <= '0;
      dv_nx_q[0]  <= QW'(nxmag) << FRAC_BITS;
      dv_ny_q[0]  <= QW'(nymag) << FRAC_BITS;
      dv_qx_q[0]  <= '0;
      dv_qy_q[0]  <= '0;
    end
  end

  // Restoring division, one quotient bit per stage for both x and y. The partial
  // remainder stays below a nonzero divisor, so MW bits hold it.
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [MW:0]   trial_x, trial_y;
    logic          ge_x, ge_y;
    logic [MW-1:0] rem_x_d, rem_y_d;

    assign trial_x = {dv_rx_q[k], dv_nx_q[k][QW-1]};
    assign trial_y = {dv_ry_q[k], dv_ny_q[k][QW-1]};
    assign ge_x    = trial_x >= {1'b0, dv_den_q[k]};
    assign ge_y    = trial_y >= {1'b0, dv_den_q[k]};
    assign rem_x_d = ge_x ? MW'(trial_x - {1'b0, dv_den_q[k]}) : MW'(trial_x);
    assign rem_y_d = ge_y ? MW'(trial_y - {1'b0, dv_den_q[k]}) : MW'(trial_y);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_sng_q[k+1] <= dv_sng_q[k];
        dv_ngx_q[k+1] <= dv_ngx_q[k];
        dv_ngy_q[k+1] <= dv_ngy_q[k];
        dv_den_q[k+1] <= dv_den_q[k];
        dv_rx_q[k+1]  <= rem_x_d;
        dv_ry_q[k+1]  <= rem_y_d;
        dv_nx_q[k+1]  <= dv_nx_q[k] << 1;
        dv_ny_q[k+1]  <= dv_ny_q[k] << 1;
        dv_qx_q[k+1]  <= {dv_qx_q[k][QW-2:0], ge_x};
        dv_qy_q[k+1]  <= {dv_qy_q[k][QW-2:0], ge_y};
      end
    end
  end

  // Final stage: saturate each magnitude to its signed limit, then apply the sign; singular gives zeros.
  // A negative result may reach -2^(OW-1); a positive one only 2^(OW-1)-1.
  logic [EW-1:0] cap_x, cap_y, qx_e, qy_e, sat_x, sat_y, res_x, res_y;

  assign cap_x = dv_ngx_q[QW] ? (EW'(1) << (OW - 1)) : ((EW'(1) << (OW - 1)) - EW'(1));
  assign cap_y = dv_ngy_q[QW] ? (EW'(1) << (OW - 1)) : ((EW'(1) << (OW - 1)) - EW'(1));
  assign qx_e  = EW'(dv_qx_q[QW]);
  assign qy_e  = EW'(dv_qy_q[QW]);
  assign sat_x = (qx_e > cap_x) ? cap_x : qx_e;
  assign sat_y = (qy_e > cap_y) ? cap_y : qy_e;
  assign res_x = dv_ngx_q[QW] ? (EW'(0) - sat_x) : sat_x;
  assign res_y = dv_ngy_q[QW] ? (EW'(0) - sat_y) : sat_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q.status <= dv_sng_q[QW];
      out_data_q.sol_x  <= dv_sng_q[QW] ? '0 : $signed(res_x[OW-1:0]);
      out_data_q.sol_y  <= dv_sng_q[QW] ? '0 : $signed(res_y[OW-1:0]);
    end
  end

endmodule
